>>> rtl/ema_pkg.sv
// Package for the epoch matrix averager: method codes, widths, shared types.
// No dependencies.
package ema_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned SUM_W    = 38;
    localparam int unsigned IDX_W    = 8;
    localparam int unsigned DIVD_W   = 39;
    localparam int unsigned DIVS_W   = 33;

    typedef enum logic [2:0] {
        METH_MOVING    = 3'd0,
        METH_MOVING_IM = 3'd1,
        METH_BLOCK     = 3'd2,
        METH_CUMUL     = 3'd3,
        METH_NONE      = 3'd4
    } t_method;

    localparam logic [1:0] REG_METHOD = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_ELEMS  = 2'd2;

    localparam logic CMD_FEED  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                start;
        logic signed [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [DIVD_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic                  cmd;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average;
        logic [IDX_W-1:0]      element_index;
        logic                  matrix_last;
    } t_out_item;

endpackage

>>> rtl/ema_if.sv
// Valid/ready channel carrying one item of type ema_pkg t_in_item or t_out_item.
// Depends on ema_pkg.
interface ema_in_if;
    logic                valid;
    logic                ready;
    ema_pkg::t_in_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ema_out_if;
    logic                valid;
    logic                ready;
    ema_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ema_div.sv
// Bit-serial signed divider, truncating toward zero, one quotient bit a cycle.
// Depends on ema_pkg.
module ema_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ema_pkg::t_div_req i_req,
    output ema_pkg::t_div_rsp o_rsp
);
    localparam int unsigned DW = ema_pkg::DIVD_W;
    localparam int unsigned SW = ema_pkg::DIVS_W;
    localparam int unsigned CW = $clog2(DW + 1);

    logic [DW-1:0]   r_quo, n_quo;
    logic [SW:0]     r_rem, n_rem;
    logic [SW-1:0]   r_den;
    logic            r_neg;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [SW:0]     w_trial;
    logic [DW-1:0]   w_abs;

    always_comb begin
        w_abs   = i_req.dividend[DW-1] ? DW'(-i_req.dividend) : DW'(i_req.dividend);
        w_trial = {r_rem[SW-1:0], r_quo[DW-1]} - {1'b0, r_den};
        if (!w_trial[SW]) begin
            n_rem = w_trial;
            n_quo = {r_quo[DW-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[SW-1:0], r_quo[DW-1]};
            n_quo = {r_quo[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= w_abs;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_neg  <= i_req.dividend[DW-1];
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

>>> rtl/ema_cfg.sv
// APB-style configuration registers: method, matrix count, matrix size.
// Depends on ema_pkg.
module ema_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [2:0]  o_method,
    output logic [6:0]  o_count,
    output logic [8:0]  o_elems
);
    logic [2:0] r_method;
    logic [6:0] r_count;
    logic [8:0] r_elems;
    logic       w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= 3'd0;
            r_count  <= 7'd4;
            r_elems  <= 9'd256;
        end else if (w_wr) begin
            case (paddr[3:2])
                ema_pkg::REG_METHOD: r_method <= pwdata[2:0];
                ema_pkg::REG_COUNT:  r_count  <= pwdata[6:0];
                ema_pkg::REG_ELEMS:  r_elems  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ema_pkg::REG_METHOD: prdata = {29'd0, r_method};
            ema_pkg::REG_COUNT:  prdata = {25'd0, r_count};
            ema_pkg::REG_ELEMS:  prdata = {23'd0, r_elems};
            default:             prdata = '0;
        endcase
    end

    assign o_method = r_method;
    assign o_count  = r_count;
    assign o_elems  = r_elems;
endmodule

>>> rtl/epoch_matrix_averager.sv
// Epoch matrix averager top level: sequencer, history memory, sums, divider.
// Path of an accepted element: S_READ, S_CALC, S_DIV, S_WAIT for the serial divide, then S_OUT;
// a cumulative element while the cumulative count is zero skips the divide (S_READ, S_CALC, S_OUT).
// Throughput: one item at a time, taken only in S_IDLE; a clear item or a METH_NONE element
// is handled without leaving S_IDLE; a result not taken stalls the next one.
// Reset: synchronous, active low; clears sums valid bits and bookkeeping.
module epoch_matrix_averager #(
    parameter int unsigned MAX_ELEMS  = 256,
    parameter int unsigned HIST_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ema_in_if.sink      i_in,
    ema_out_if.source   o_out
);
    localparam int unsigned EW   = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int unsigned HW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int unsigned MAXE = (MAX_ELEMS < 256) ? MAX_ELEMS : 256;
    localparam int unsigned SW   = ema_pkg::SUM_W;
    localparam int unsigned DW   = ema_pkg::DIVD_W;
    localparam int unsigned HN   = HIST_DEPTH * MAX_ELEMS;
    localparam int unsigned AW   = (HN > 1) ? $clog2(HN) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CALC, S_DIV, S_WAIT, S_OUT
    } t_state;

    logic [2:0] w_method;
    logic [6:0] w_count;
    logic [8:0] w_elems;

    ema_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_method(w_method), .o_count(w_count), .o_elems(w_elems)
    );

    logic signed [31:0] r_hist [HIST_DEPTH*MAX_ELEMS];
    logic signed [SW-1:0] r_sum [MAX_ELEMS];
    logic [MAX_ELEMS-1:0] r_sum_vld;
    logic signed [31:0] r_mean [MAX_ELEMS];

    t_state r_state;
    logic [6:0]  r_held;
    logic [HW-1:0] r_oldest;
    logic [8:0]  r_pos;
    logic [31:0] r_ccnt;
    logic [EW-1:0] r_p;
    logic        r_last;
    logic [2:0]  r_mode;
    logic [6:0]  r_cnt;
    logic signed [31:0] r_x;
    logic signed [31:0] r_hrd, r_mrd;
    logic signed [SW-1:0] r_srd;
    logic        r_svld;
    logic [6:0]  r_newheld;
    logic        r_emit;
    logic [32:0] r_k;
    logic signed [31:0] r_avg;
    logic        r_ovld;
    ema_pkg::t_out_item r_odata;
    ema_pkg::t_div_req  w_req;
    ema_pkg::t_div_rsp  w_rsp;

    logic [8:0]  w_elc;
    logic [6:0]  w_cnc;
    logic [8:0]  w_p;
    logic        w_repl;
    logic [6:0]  w_base;
    logic [HW:0] w_slot_sum;
    logic [HW-1:0] w_slot;
    logic [AW-1:0] w_hidx;
    logic signed [SW-1:0] w_sum_old, w_sum;
    logic signed [DW-1:0] w_q;
    logic signed [32:0] w_diff;

    always_comb begin
        w_elc = (w_elems == 9'd0) ? 9'd1 : ((w_elems > 9'(MAXE)) ? 9'(MAXE) : w_elems);
        w_cnc = (w_count == 7'd0) ? 7'd1 :
                ((32'(w_count) > HIST_DEPTH) ? 7'(HIST_DEPTH) : w_count);
        w_p   = (r_pos < w_elc) ? r_pos : 9'd0;
        w_repl = (r_mode != ema_pkg::METH_BLOCK) && (r_held >= r_cnt);
        w_base = (r_mode == ema_pkg::METH_BLOCK && r_held >= r_cnt) ? 7'd0 : r_held;
        w_slot_sum = {1'b0, r_oldest} + (HW+1)'(w_base);
        w_slot = (32'(w_slot_sum) >= HIST_DEPTH) ? HW'(32'(w_slot_sum) - HIST_DEPTH)
                                                 : w_slot_sum[HW-1:0];
        w_hidx = AW'(32'(w_repl ? r_oldest : w_slot) * MAX_ELEMS + 32'(r_p));
        w_sum_old = r_svld ? r_srd : '0;
        if (w_repl)
            w_sum = w_sum_old - SW'(r_hrd) + SW'(r_x);
        else if (w_base != 7'd0)
            w_sum = w_sum_old + SW'(r_x);
        else
            w_sum = SW'(r_x);
        w_diff = 33'(r_x) - 33'(r_mrd);
        w_q = w_rsp.quotient;
    end

    assign w_req.start    = (r_state == S_DIV);
    assign w_req.dividend = (r_mode == ema_pkg::METH_CUMUL) ? DW'(w_diff) : DW'(r_srd);
    assign w_req.divisor  = (r_mode == ema_pkg::METH_CUMUL) ? r_k : 33'(r_newheld);

    ema_div u_div (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovld;
    assign o_out.data  = r_odata;

    function automatic logic signed [31:0] f_sat(input logic signed [DW-1:0] v);
        if (v > DW'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
        if (v < -DW'(33'sh80000000)) return 32'sh80000000;
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_hrd <= r_hist[w_hidx];
            r_srd <= r_sum[r_p];
            r_svld <= r_sum_vld[r_p];
            r_mrd <= r_mean[r_p];
        end else if (r_state == S_CALC) begin
            r_srd <= w_sum;
        end
        if (r_state == S_CALC && r_mode <= ema_pkg::METH_BLOCK) begin
            r_hist[w_hidx] <= r_x;
            r_sum[r_p] <= w_sum;
        end
        if (r_state == S_CALC && r_mode == ema_pkg::METH_CUMUL && r_k == 33'd1)
            r_mean[r_p] <= r_x;
        if (r_state == S_WAIT && w_rsp.done && r_mode == ema_pkg::METH_CUMUL)
            r_mean[r_p] <= f_sat(DW'(r_mrd) + w_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_held    <= '0;
            r_oldest  <= '0;
            r_pos     <= '0;
            r_ccnt    <= '0;
            r_sum_vld <= '0;
            r_ovld    <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ovld || o_out.ready))
                r_ovld <= r_emit;
            else if (o_out.valid && o_out.ready)
                r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.data.cmd == ema_pkg::CMD_CLEAR) begin
                            r_held <= '0;
                            r_pos  <= '0;
                        end else begin
                            r_x    <= i_in.data.sample;
                            r_mode <= w_method;
                            r_cnt  <= w_cnc;
                            r_p    <= EW'(w_p);
                            r_last <= (w_p == w_elc - 9'd1);
                            r_pos  <= (w_p == w_elc - 9'd1) ? 9'd0 : w_p + 9'd1;
                            r_k    <= (r_ccnt == 32'hFFFFFFFF) ? 33'hFFFFFFFF
                                                               : 33'(r_ccnt) + 33'd1;
                            r_state <= (w_method <= ema_pkg::METH_CUMUL) ? S_READ : S_IDLE;
                        end
                    end
                end
                S_READ: r_state <= S_CALC;
                S_CALC: begin
                    if (r_mode == ema_pkg::METH_CUMUL) begin
                        r_emit <= 1'b1;
                        if (r_last) begin
                            r_ccnt <= r_k[31:0];
                            r_held <= '0;
                        end
                        if (r_k == 33'd1) begin
                            r_avg <= r_x;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_sum_vld[r_p] <= 1'b1;
                        r_newheld <= w_repl ? r_held : w_base + 7'd1;
                        r_emit <= (r_mode == ema_pkg::METH_MOVING_IM) ||
                                  ((w_repl ? r_held : w_base + 7'd1) == r_cnt);
                        if (r_last) begin
                            r_held <= w_repl ? r_held : w_base + 7'd1;
                            if (w_repl)
                                r_oldest <= (HW'(r_oldest) + 1'b1) == HW'(HIST_DEPTH) ||
                                            HIST_DEPTH == 1 ? '0 : r_oldest + 1'b1;
                        end
                        r_state <= S_DIV;
                    end
                end
                S_DIV: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_rsp.done) begin
                        r_avg <= (r_mode == ema_pkg::METH_CUMUL) ?
                                 f_sat(DW'(r_mrd) + w_q) : f_sat(w_q);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovld || o_out.ready) begin
                        r_odata.average <= r_avg;
                        r_odata.element_index <= 8'(r_p);
                        r_odata.matrix_last <= r_last;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> r_state == S_WAIT) else $error("divider start lost");
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= HIST_DEPTH) else $error("held count out of range");
endmodule
